/* rtl/radix_converter_top_assert.svh */
// assertion macros for the radix converter
// both sample on the rising edge of clk and are off while rst_n is low
`ifndef RADIX_CONVERTER_TOP_ASSERT_SVH
`define RADIX_CONVERTER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rc_pkg.sv */
`default_nettype none

package rc_pkg;

    // digit store geometry
    localparam int MAX_DIGITS = 32;
    localparam int ADDR_W     = 5;
    localparam int COUNT_W    = 6;

    // radix limits
    localparam logic [4:0] MIN_TARGET = 5'd2;
    localparam logic [4:0] MAX_RADIX  = 5'd16;
    localparam logic [4:0] MIN_SOURCE = 5'd1;

    // character mapping
    localparam logic [3:0] DEC_BASE    = 4'd10;
    localparam logic [6:0] CHAR_ZERO   = 7'h30;
    localparam logic [6:0] CHAR_LETTER = 7'h41;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_RADIX = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // register indexes (paddr bit 2)
    localparam logic REG_SOURCE_RADIX = 1'b0;
    localparam logic REG_TARGET_RADIX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD,
        ST_ERR
    } rc_state_t;

    typedef struct packed {
        logic [3:0] digit_in;
        logic       last_in;
    } in_word_t;

    typedef struct packed {
        logic [3:0] digit_out;
        logic [6:0] char_out;
        logic       last_out;
        logic [1:0] status;
    } out_word_t;

    typedef struct packed {
        logic [4:0] source_radix;
        logic [4:0] target_radix;
    } rc_cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [3:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // ascii character of one digit
    function automatic logic [6:0] ascii_of(input logic [3:0] d);
        logic [6:0] ch;
        if (d < DEC_BASE)
        begin
            ch = CHAR_ZERO + 7'(d);
        end
        else
        begin
            ch = CHAR_LETTER + 7'(d - DEC_BASE);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/rc_chan_if.sv */
`default_nettype none

interface rc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/rc_apb_regs.sv */
`default_nettype none

module rc_apb_regs
    import rc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output rc_cfg_t          cfg
);

    logic [4:0] source_reg;
    logic [4:0] target_reg;
    logic       wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= 5'd10;
            target_reg <= 5'd2;
        end
        else if (wr_fire)
        begin
            unique case (paddr[2])
                REG_SOURCE_RADIX: source_reg <= pwdata[4:0];
                REG_TARGET_RADIX: target_reg <= pwdata[4:0];
                default:          source_reg <= source_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[2])
            REG_SOURCE_RADIX: prdata = {27'd0, source_reg};
            REG_TARGET_RADIX: prdata = {27'd0, target_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.source_radix = source_reg;
    assign cfg.target_radix = target_reg;

endmodule

`default_nettype wire

/* rtl/rc_div_unit.sv */
`default_nettype none

module rc_div_unit
    import rc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [4:0]            divisor,
    output logic                       done,
    output logic      [VALUE_BITS-1:0] quotient,
    output logic      [3:0]            remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [3:0]            rem_reg;
    logic [4:0]            div_reg;
    logic [4:0]            trial;
    logic [4:0]            diff;
    logic                  fits;

    // one restoring shift-subtract step per cycle
    assign trial = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff  = trial - div_reg;
    assign fits  = (trial >= div_reg);

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(VALUE_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= 4'd0;
            div_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
            rem_reg  <= fits ? diff[3:0] : trial[3:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/rc_digit_buf.sv */
`default_nettype none

module rc_digit_buf
    import rc_pkg::*;
(
    input  wire logic       clk,
    input  wire mem_req_t   req,
    output logic      [3:0] rd_data
);

    logic [3:0] mem [MAX_DIGITS];
    logic [3:0] rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/radix_converter_top.sv */
// channel  dir  word fields                              handshake
// din      in   digit_in[3:0] last_in                    valid/ready
// dout     out  digit_out[3:0] char_out[6:0] last_out    valid/ready
//               status[1:0]
// apb      in   source_radix @0x0, target_radix @0x4     psel/penable, pready=1
//
// the multiply-add of a digit that is not last is done on accept
// a last digit runs the shared bit-serial divider once per target digit, then
// each emitted word takes a store read (ST_RD) and an output load (ST_LOAD)
// an error word is loaded in ST_ERR after the last digit, once the output register is free
// rst_n is asynchronous; the digit store is not cleared and needs no pass
// a stalled dout holds its output register and the sequencer waits on it to load a word
`default_nettype none

module radix_converter_top
    import rc_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rc_chan_if.sink          din,
    rc_chan_if.source        dout,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int WIDE_W = VALUE_BITS + 5;

    rc_cfg_t               cfg;
    rc_state_t             state_reg, state_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [COUNT_W-1:0]    n_reg, n_next;
    logic [ADDR_W-1:0]     k_reg, k_next;
    logic [1:0]            err_reg, err_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_word_reg, out_word_next;

    logic [4:0]            radix_eff;
    logic [WIDE_W-1:0]     sum;
    logic                  ovf_hit;
    logic                  tgt_ok;
    logic                  in_fire;
    logic                  out_free;
    logic                  last_k;
    logic [COUNT_W-1:0]    rd_idx;
    in_word_t              in_word;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [3:0]            div_rem;

    mem_req_t              mem_req;
    logic [3:0]            mem_rd_data;

    rc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rc_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cfg.target_radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    rc_digit_buf u_buf (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign in_word = din.payload;

    // clamp source radix to 1..16
    always_comb
    begin
        if (cfg.source_radix < MIN_SOURCE)
        begin
            radix_eff = MIN_SOURCE;
        end
        else if (cfg.source_radix > MAX_RADIX)
        begin
            radix_eff = MAX_RADIX;
        end
        else
        begin
            radix_eff = cfg.source_radix;
        end
    end

    // accumulate: value * radix + digit, overflow from the upper bits
    assign sum     = WIDE_W'(acc_reg) * WIDE_W'(radix_eff) + WIDE_W'(in_word.digit_in);
    assign ovf_hit = |sum[WIDE_W-1:VALUE_BITS];
    assign tgt_ok  = (cfg.target_radix >= MIN_TARGET) && (cfg.target_radix <= MAX_RADIX);

    assign din.ready  = (state_reg == ST_IDLE);
    assign in_fire    = din.valid && din.ready;
    assign out_free   = !out_valid_reg || dout.ready;
    assign rd_idx     = n_reg - COUNT_W'(1) - COUNT_W'(k_reg);
    assign last_k     = (COUNT_W'(k_reg) == n_reg - COUNT_W'(1));

    assign dout.valid   = out_valid_reg;
    assign dout.payload = out_word_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_word_next  = out_word_reg;
        div_start      = 1'b0;
        div_dividend   = div_quot;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next = sum[VALUE_BITS-1:0];
                    ovf_next = ovf_reg || ovf_hit;
                    if (in_word.last_in)
                    begin
                        acc_next = '0;
                        ovf_next = 1'b0;
                        n_next   = '0;
                        if (!tgt_ok)
                        begin
                            err_next   = STATUS_BAD_RADIX;
                            state_next = ST_ERR;
                        end
                        else if (ovf_reg || ovf_hit)
                        begin
                            err_next   = STATUS_OVERFLOW;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = sum[VALUE_BITS-1:0];
                            state_next   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = n_reg[ADDR_W-1:0];
                    mem_req.wr_data = div_rem;
                    n_next          = n_reg + COUNT_W'(1);
                    if (div_quot == '0)
                    begin
                        k_next     = '0;
                        state_next = ST_RD;
                    end
                    else if (n_reg == COUNT_W'(MAX_DIGITS - 1))
                    begin
                        // more target digits than the store holds
                        n_next     = '0;
                        err_next   = STATUS_OVERFLOW;
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = rd_idx[ADDR_W-1:0];
                state_next      = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.digit_out = mem_rd_data;
                    out_word_next.char_out  = ascii_of(mem_rd_data);
                    out_word_next.last_out  = last_k;
                    out_word_next.status    = STATUS_OK;
                    if (last_k)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.digit_out = 4'd0;
                    out_word_next.char_out  = 7'd0;
                    out_word_next.last_out  = 1'b1;
                    out_word_next.status    = err_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

`include "radix_converter_top_assert.svh"

    // divider finishes only while the sequencer waits on it
    `RC_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider done outside DIV")

    // a last digit leaves the accumulator and overflow flag clear
    `RC_ASSERT_NEXT(a_last_clears_acc, in_fire && in_word.last_in, acc_reg == '0 && !ovf_reg,
        "accumulator not cleared after last digit")

    // store reads stay inside the digits of this conversion
    `RC_ASSERT_SAME(a_rd_in_range, state_reg == ST_RD,
        n_reg != '0 && COUNT_W'(k_reg) < n_reg, "digit store read out of range")

    // error words carry a zero digit and close the conversion
    `RC_ASSERT_SAME(a_err_word, out_valid_reg && out_word_reg.status != STATUS_OK,
        out_word_reg.last_out && out_word_reg.digit_out == 4'd0, "malformed error word")

endmodule

`default_nettype wire
